// ----- rtl/link_delay_release_queue_top_assert.svh -----
// Assertion macros used by the link delay release queue top level.
`ifndef LINK_DELAY_RELEASE_QUEUE_TOP_ASSERT_SVH
`define LINK_DELAY_RELEASE_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LDRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LDRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ldrq_pkg.sv -----
// Types and constants of the link delay release queue.
`timescale 1ns / 1ps

package ldrq_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DELAY_W = 20;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAJORITY_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINORITY_DELAY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   packet_id;
        logic [TIME_W-1:0] timestamp;
        logic              delay_change;
        logic              use_majority;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   released_id;
        logic [TIME_W-1:0] arrival_time;
        logic              dropped;
        logic              last;
    } t_out_item;

    // Verdict of the departure check for the oldest entry
    typedef struct packed {
        logic              leave;
        logic [TIME_W-1:0] arrival;
    } t_depart_res;

    // Stored entry: id in the upper half, timestamp in the lower half
    localparam int unsigned ENTRY_W = ID_W + TIME_W;

endpackage

// ----- rtl/link_delay_release_queue_top.sv -----
// Top level of the link delay release queue: sequencer, pointers, queue RAM.
//
//  channel   direction  handshake                       payload
//  ------    ---------  ------------------------------  -----------------------
//  item in   input      start & !busy                   i_in (t_in_item)
//  result    output     o_result_strobe, one cycle      o_result (t_out_item)
//  config    input      i_cfg_we                        i_cfg_index, i_cfg_data
//
// For each item the sequencer pushes it (unless the queue is full) and issues
// the RAM read of the oldest entry, then makes one check per cycle on the
// single RAM read port: one per released entry and a final check that stops
// the drain. Each result appears in the cycle after the check that fixes its
// last flag; the receiver cannot stall. Reset is synchronous, active low, and
// empties the queue at once: the RAM needs no clearing pass.
`timescale 1ns / 1ps

module link_delay_release_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  ldrq_pkg::t_in_item                     i_in,
    output logic                                   o_result_strobe,
    output ldrq_pkg::t_out_item                    o_result,
    input  logic                                   i_cfg_we,
    input  logic [ldrq_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ldrq_pkg::DELAY_W-1:0]           i_cfg_data
);

`include "link_delay_release_queue_top_assert.svh"

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned IW = ldrq_pkg::ID_W;
    localparam int unsigned TW = ldrq_pkg::TIME_W;
    localparam int unsigned DW = ldrq_pkg::DELAY_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    // control registers
    t_state        r_state, n_state;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [TW-1:0] r_last_dep, n_last_dep;
    logic          r_fwd, n_fwd;
    logic          r_drop, n_drop;
    logic          r_pend_valid, n_pend_valid;
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_base_delay, r_major_delay, r_minor_delay;

    // payload registers
    logic [IW-1:0]       r_cur_id, n_cur_id;
    logic [TW-1:0]       r_now, n_now;
    logic [DW-1:0]       r_step_delay, n_step_delay;
    logic [IW-1:0]       r_pend_id, n_pend_id;
    logic [TW-1:0]       r_pend_arr, n_pend_arr;
    ldrq_pkg::t_out_item r_out, n_out;

    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_go;
    logic [PW-1:0]                 w_head_inc;
    logic [PW-1:0]                 w_tail_inc;
    logic [PW-1:0]                 w_raddr;
    logic                          w_ram_we;
    logic [ldrq_pkg::ENTRY_W-1:0]  w_wdata;
    logic [ldrq_pkg::ENTRY_W-1:0]  w_rdata;
    logic [IW-1:0]                 w_entry_id;
    logic [TW-1:0]                 w_entry_time;
    ldrq_pkg::t_depart_res         w_dep;

    // ring pointer arithmetic
    assign w_head_inc = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign w_tail_inc = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PW'(1);
    assign w_full     = (w_head_inc == r_tail);
    assign w_empty    = (r_head == r_tail);

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && (r_state == S_IDLE);

    // queue RAM: push at head on accept when not full, read oldest entry
    assign w_ram_we = w_accept && !w_full;
    assign w_wdata  = {i_in.packet_id, i_in.timestamp};
    assign w_raddr  = (r_state == S_EVAL && w_go) ? w_tail_inc : r_tail;

    ldrq_ram #(
        .WIDTH (ldrq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_head),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // a push into an empty queue is read back in the same cycle: forward it
    assign w_entry_id   = r_fwd ? r_cur_id : w_rdata[ldrq_pkg::ENTRY_W-1:TW];
    assign w_entry_time = r_fwd ? r_now    : w_rdata[TW-1:0];

    ldrq_depart u_depart (
        .i_entry_time (w_entry_time),
        .i_now        (r_now),
        .i_base_delay (r_base_delay),
        .i_step_delay (r_step_delay),
        .i_last_dep   (r_last_dep),
        .o_res        (w_dep)
    );

    assign w_go = !w_empty && w_dep.leave;

    // sequencer: accept, then one departure check per cycle
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_last_dep   = r_last_dep;
        n_fwd        = r_fwd;
        n_drop       = r_drop;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_arr   = r_pend_arr;
        n_cur_id     = r_cur_id;
        n_now        = r_now;
        n_step_delay = r_step_delay;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cur_id     = i_in.packet_id;
                    n_now        = i_in.timestamp;
                    n_step_delay = i_in.delay_change
                                 ? (i_in.use_majority ? r_major_delay : r_minor_delay)
                                 : r_base_delay;
                    n_drop       = w_full;
                    n_fwd        = !w_full && w_empty;
                    if (!w_full) begin
                        n_head = w_head_inc;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                n_fwd = 1'b0;
                if (w_go) begin
                    // release; the previous release is now known not to be last
                    n_tail     = w_tail_inc;
                    n_last_dep = w_dep.arrival;
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = '{released_id: r_pend_id, arrival_time: r_pend_arr,
                                        dropped: r_drop, last: 1'b0};
                    end
                    n_pend_valid = 1'b1;
                    n_pend_id    = w_entry_id;
                    n_pend_arr   = w_dep.arrival;
                end else begin
                    // drain stops: close the item
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = '{released_id: r_pend_id, arrival_time: r_pend_arr,
                                        dropped: r_drop, last: 1'b1};
                    end else if (r_drop) begin
                        n_out_valid = 1'b1;
                        n_out       = '{released_id: '0, arrival_time: '0,
                                        dropped: 1'b1, last: 1'b1};
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_last_dep    <= '0;
            r_fwd         <= 1'b0;
            r_drop        <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_base_delay  <= '0;
            r_major_delay <= '0;
            r_minor_delay <= '0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_last_dep   <= n_last_dep;
            r_fwd        <= n_fwd;
            r_drop       <= n_drop;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ldrq_pkg::CFG_BASE_DELAY:     r_base_delay  <= i_cfg_data;
                    ldrq_pkg::CFG_MAJORITY_DELAY: r_major_delay <= i_cfg_data;
                    ldrq_pkg::CFG_MINORITY_DELAY: r_minor_delay <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cur_id     <= n_cur_id;
        r_now        <= n_now;
        r_step_delay <= n_step_delay;
        r_pend_id    <= n_pend_id;
        r_pend_arr   <= n_pend_arr;
        r_out        <= n_out;
    end

    assign o_result_strobe = r_out_valid;
    assign o_result        = r_out;

    // results of one item come in an unbroken run, and nothing follows the last
    `LDRQ_ASSERT_NEXT(a_idle_no_result, i_clk, i_rst_n, r_state == S_IDLE, !o_result_strobe, "result strobe one cycle after idle")
    `LDRQ_ASSERT_NEXT(a_run_unbroken, i_clk, i_rst_n, o_result_strobe && !o_result.last, o_result_strobe, "gap inside a run of results")
    `LDRQ_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, o_result_strobe && o_result.last, !o_result_strobe, "result after the last one")
    `LDRQ_ASSERT_NOW(a_fwd_first_check, i_clk, i_rst_n, r_fwd, r_state == S_EVAL && !r_pend_valid && !w_empty, "forwarding outside the first check")

endmodule

// ----- rtl/ldrq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ldrq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ldrq_depart.sv -----
// Departure check: due time, ordering against the last departure, arrival tick.
`timescale 1ns / 1ps

module ldrq_depart (
    input  logic [ldrq_pkg::TIME_W-1:0]  i_entry_time,
    input  logic [ldrq_pkg::TIME_W-1:0]  i_now,
    input  logic [ldrq_pkg::DELAY_W-1:0] i_base_delay,
    input  logic [ldrq_pkg::DELAY_W-1:0] i_step_delay,
    input  logic [ldrq_pkg::TIME_W-1:0]  i_last_dep,
    output ldrq_pkg::t_depart_res        o_res
);

    localparam int unsigned TW = ldrq_pkg::TIME_W;

    logic [TW:0]   w_due_base;
    logic [TW:0]   w_due_step;
    logic [TW:0]   w_now_x;
    logic [TW:0]   w_due;
    logic          w_due_ok;
    logic [TW-1:0] w_last_inc;

    // due times at full width, no wrap
    assign w_now_x    = {1'b0, i_now};
    assign w_due_base = {1'b0, i_entry_time} + {{(TW + 1 - ldrq_pkg::DELAY_W){1'b0}}, i_base_delay};
    assign w_due_step = {1'b0, i_entry_time} + {{(TW + 1 - ldrq_pkg::DELAY_W){1'b0}}, i_step_delay};
    assign w_last_inc = i_last_dep + {{(TW - 1){1'b0}}, 1'b1};

    // base delay first, step delay only if base is not yet due
    always_comb begin
        priority if (w_due_base <= w_now_x) begin
            w_due    = w_due_base;
            w_due_ok = 1'b1;
        end else if (w_due_step <= w_now_x) begin
            w_due    = w_due_step;
            w_due_ok = 1'b1;
        end else begin
            w_due    = w_due_step;
            w_due_ok = 1'b0;
        end
    end

    // keep departures in order: behind the last one, or one tick after it
    always_comb begin
        o_res.leave   = 1'b0;
        o_res.arrival = w_due[TW-1:0];
        if (w_due_ok) begin
            priority if (w_due >= {1'b0, i_last_dep}) begin
                o_res.leave   = 1'b1;
                o_res.arrival = w_due[TW-1:0];
            end else if (i_last_dep <= i_now) begin
                o_res.leave   = 1'b1;
                o_res.arrival = w_last_inc;
            end else begin
                o_res.leave   = 1'b0;
                o_res.arrival = w_due[TW-1:0];
            end
        end
    end

endmodule
